[design/sear_pkg.sv]
// Shared types and constants of the sleep epoch activity recorder.
package sear_pkg;

    // Action codes of an input word
    localparam logic [1:0] ACT_MOVE  = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_CLOSE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_START  = 2'd0;
    localparam logic [1:0] REG_END    = 2'd1;
    localparam logic [1:0] REG_THRESH = 2'd2;

    localparam logic [4:0]  HOURS_PER_DAY   = 5'd24;
    localparam logic [4:0]  START_RESET     = 5'd22;
    localparam logic [4:0]  END_RESET       = 5'd8;
    localparam logic [15:0] THRESH_RESET    = 16'd10;
    localparam logic [15:0] COUNT_MAX       = 16'hFFFF;

    // Largest number of epochs the 8-bit index and 4-word bitmap can hold
    localparam int          EPOCH_HW_MAX    = 128;
    localparam int          BITMAP_WORDS    = 4;

    // seconds / 3600 = (seconds >> 4) / 225, done as multiply by 2^36/225 rounded up
    localparam logic [28:0] RECIP_225       = 29'd305419897;
    localparam int          RECIP_225_SHIFT = 36;
    // q / 24 = (q >> 3) / 3, done as multiply by 2^20/3 rounded up
    localparam logic [18:0] RECIP_3         = 19'd349526;
    localparam int          RECIP_3_SHIFT   = 20;

    typedef struct packed {
        logic       load_in;
        logic       mul1;
        logic       mul2;
        logic       exec;
        logic       emit;
        logic       last;
        logic [1:0] word;
    } t_dp_cmd;

    typedef struct packed {
        logic close_open;
        logic out_free;
    } t_dp_stat;

endpackage

[design/sleep_epoch_activity_recorder.sv]
// Top level of the sleep epoch activity recorder.
//
//   channel  direction  handshake                  payload
//   in       to block   i_in_valid / o_in_stall    i_action, i_now_seconds
//   out      from block o_out_valid / i_out_stall  o_night_date, o_epochs_recorded,
//                                                  o_word_index, o_bitmap_word, o_last
//   cfg      to block   i_cfg_we (no wait)         i_cfg_index, i_cfg_data
//
// An input word passes through accept, two reciprocal multiplies that turn seconds
// into the hour of day, then the state update. A close of an open night then streams
// its bitmap words (1 to 4, from EPOCH_LIMIT), each as the output register frees.
// A stalled output holds its word; input stays stalled until the final word of a record
// is in the output register, after which new input is taken while that word waits.
// Synchronous reset restores the window 22 to 8, threshold 10, and clears the night.
module sleep_epoch_activity_recorder #(
    parameter int EPOCH_LIMIT = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_now_seconds,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_night_date,
    output logic [7:0]  o_epochs_recorded,
    output logic [1:0]  o_word_index,
    output logic [31:0] o_bitmap_word,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import sear_pkg::*;

    localparam int CAP   = (EPOCH_LIMIT < EPOCH_HW_MAX) ? EPOCH_LIMIT : EPOCH_HW_MAX;
    localparam int WORDS = (CAP + 31) / 32;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    sear_ctrl #(
        .WORDS (WORDS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    sear_datapath #(
        .CAP   (CAP),
        .WORDS (WORDS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_action          (i_action),
        .i_now_seconds     (i_now_seconds),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_night_date      (o_night_date),
        .o_epochs_recorded (o_epochs_recorded),
        .o_word_index      (o_word_index),
        .o_bitmap_word     (o_bitmap_word),
        .o_last            (o_last)
    );

endmodule

[design/sear_ctrl.sv]
// Sequencer of the sleep epoch activity recorder: item steps and record streaming.
module sear_ctrl #(
    parameter int WORDS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  sear_pkg::t_dp_stat i_stat,
    output sear_pkg::t_dp_cmd  o_cmd
);
    import sear_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_MUL2 = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    localparam logic [1:0] LAST_WORD = 2'(WORDS - 1);

    logic [2:0] r_state, n_state;
    logic [1:0] r_word, n_word;

    always_comb begin
        n_state = r_state;
        n_word  = r_word;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_word     = '0;
                n_state    = i_stat.close_open ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                // advance only when the output register can take a word
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.word = r_word;
                    o_cmd.last = (r_word == LAST_WORD);
                    if (r_word == LAST_WORD) begin
                        n_state = S_IDLE;
                    end else begin
                        n_word = r_word + 2'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_word  <= '0;
        end else begin
            r_state <= n_state;
            r_word  <= n_word;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_MUL1))
        else $error("accepted word did not start the hour computation");

    a_emit_only_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && n_state == S_EMIT) |-> i_stat.close_open)
        else $error("record streamed without an open night");

    a_word_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_word <= LAST_WORD))
        else $error("word counter beyond the record length");

endmodule

[design/sear_datapath.sv]
// Datapath of the sleep epoch activity recorder: hour, night state, bitmap, output.
module sear_datapath #(
    parameter int CAP   = 128,
    parameter int WORDS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sear_pkg::t_dp_cmd  i_cmd,
    output sear_pkg::t_dp_stat o_stat,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic [1:0]         i_action,
    input  logic [31:0]        i_now_seconds,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [31:0]        o_night_date,
    output logic [7:0]         o_epochs_recorded,
    output logic [1:0]         o_word_index,
    output logic [31:0]        o_bitmap_word,
    output logic               o_last
);
    import sear_pkg::*;

    localparam logic [7:0] CAP_CODE   = 8'(CAP);
    localparam logic [1:0] LAST_WORD  = 2'(WORDS - 1);

    // configuration
    logic [4:0]  r_start, r_end;
    logic [15:0] r_thresh;

    // captured input word and hour pipeline
    logic [1:0]  r_action;
    logic [31:0] r_now;
    logic [20:0] r_quot;
    logic [15:0] r_div24;

    // night state
    logic [15:0] r_count;
    logic [7:0]  r_epoch;
    logic        r_open;
    logic [31:0] r_stamp;
    logic [31:0] r_bits [BITMAP_WORDS];

    logic        r_out_valid;

    logic [56:0] w_prod1;
    logic [36:0] w_prod2;
    logic [20:0] w_hour_full;
    logic [4:0]  w_hour;
    logic        w_in_win;
    logic        w_record;

    assign w_prod1     = {1'b0, r_now[31:4]} * {28'd0, RECIP_225};
    assign w_prod2     = {1'b0, r_quot[20:3]} * {18'd0, RECIP_3};
    assign w_hour_full = r_quot - ({1'b0, r_div24, 4'd0} + {2'd0, r_div24, 3'd0});
    assign w_hour      = w_hour_full[4:0];

    always_comb begin
        if (r_start == r_end) begin
            w_in_win = 1'b0;
        end else if (r_start < r_end) begin
            w_in_win = (w_hour >= r_start) && (w_hour < r_end);
        end else begin
            w_in_win = (w_hour >= r_start) || (w_hour < r_end);
        end
    end

    assign w_record = w_in_win && (r_epoch < CAP_CODE);

    // configuration writes; start and end hours whose low five bits are 24 or more are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= START_RESET;
            r_end    <= END_RESET;
            r_thresh <= THRESH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_START: begin
                    if (i_cfg_data[4:0] < HOURS_PER_DAY) r_start <= i_cfg_data[4:0];
                end
                REG_END: begin
                    if (i_cfg_data[4:0] < HOURS_PER_DAY) r_end <= i_cfg_data[4:0];
                end
                REG_THRESH: begin
                    r_thresh <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_action <= i_action;
            r_now    <= i_now_seconds;
        end
        if (i_cmd.mul1) begin
            r_quot <= w_prod1[RECIP_225_SHIFT +: 21];
        end
        if (i_cmd.mul2) begin
            r_div24 <= w_prod2[RECIP_3_SHIFT +: 16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_epoch <= '0;
            r_open  <= 1'b0;
            r_stamp <= '0;
            for (int i = 0; i < BITMAP_WORDS; i++) begin
                r_bits[i] <= '0;
            end
        end else if (i_cmd.emit && i_cmd.last) begin
            // record is out: drop the night
            r_count <= '0;
            r_epoch <= '0;
            r_open  <= 1'b0;
            r_stamp <= '0;
            for (int i = 0; i < BITMAP_WORDS; i++) begin
                r_bits[i] <= '0;
            end
        end else if (i_cmd.exec) begin
            case (r_action)
                ACT_MOVE: begin
                    if (w_in_win && r_count != COUNT_MAX) begin
                        r_count <= r_count + 16'd1;
                    end
                end
                ACT_TICK: begin
                    if (w_record) begin
                        if (!r_open) begin
                            r_stamp <= r_now;
                            r_open  <= 1'b1;
                        end
                        if (r_count >= r_thresh) begin
                            r_bits[r_epoch[6:5]][r_epoch[4:0]] <= 1'b1;
                        end
                        r_epoch <= r_epoch + 8'd1;
                    end
                    r_count <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // output register: load a word when free, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_night_date      <= r_stamp;
            o_epochs_recorded <= r_epoch;
            o_word_index      <= i_cmd.word;
            o_bitmap_word     <= r_bits[i_cmd.word];
            o_last            <= i_cmd.last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_stat.close_open = (r_action == ACT_CLOSE) && r_open;
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

    a_epoch_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epoch <= CAP_CODE)
        else $error("epoch index past the cap");

    a_hour_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |-> (w_hour_full < 21'(HOURS_PER_DAY)))
        else $error("hour of day out of range");

    a_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && i_cmd.last) |=> (o_word_index == LAST_WORD && o_last))
        else $error("final word of the record mislabeled");

endmodule
